FILE: rtl/signed_elias_gamma_encoder_defines.svh
// Assertion macros shared by the signed Elias gamma encoder RTL.
// Included by every file that carries assertions; no other dependencies.
`ifndef SIGNED_ELIAS_GAMMA_ENCODER_DEFINES_SVH
`define SIGNED_ELIAS_GAMMA_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset
`define SGEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included
`define SGEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGEC_ASSERT(lbl, prop, msg)
`define SGEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/sgec_pkg.sv
// Shared types, constants and helpers for the signed Elias gamma encoder.
// No dependencies.
package sgec_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int IN_VALUE_WIDTH = 32;

  // Request codes
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // Input item
  typedef struct packed {
    logic                             req_type;
    logic signed [IN_VALUE_WIDTH-1:0] value;
  } req_item_t;

  // Result item
  typedef struct packed {
    logic [BYTE_BITS-1:0] byte_out;
    logic                 last;
  } res_item_t;

  // Commands from the sequencer to the packer
  typedef struct packed {
    logic load;   // take a new code word
    logic start;  // take the bit count of the stream
    logic step;   // move one chunk into the accumulator
    logic flush;  // pad and release the partial byte
  } pack_cmd_t;

  // Status from the packer
  typedef struct packed {
    logic                 emit;     // a byte is produced this cycle
    logic                 last;     // that byte closes the item
    logic                 done;     // stream fully consumed by this step
    logic                 pending;  // partial byte held
    logic [BYTE_BITS-1:0] data;
  } pack_stat_t;

  // Significant bits of a nibble
  function automatic logic [2:0] nib_len(input logic [3:0] n);
    logic [2:0] r;
    if (n[3])      r = 3'd4;
    else if (n[2]) r = 3'd3;
    else if (n[1]) r = 3'd2;
    else if (n[0]) r = 3'd1;
    else           r = 3'd0;
    return r;
  endfunction

endpackage

FILE: rtl/sgec_len.sv
// Code length finder: shifts the code word right a nibble per cycle.
// Depends on sgec_pkg.
`include "signed_elias_gamma_encoder_defines.svh"

module sgec_len
  import sgec_pkg::*;
#(
  parameter int CW  = 33,
  parameter int BLW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [CW-1:0] code,
  output logic          done,
  output logic [BLW-1:0] nbits
);

  localparam int LW = $clog2(CW + 1);

  logic          busy;
  logic [CW-1:0] t;
  logic [LW-1:0] len;
  logic [LW-1:0] len_final;

  // Finished once only the low nibble is left
  assign done      = busy && (t[CW-1:4] == '0);
  assign len_final = len + LW'(nib_len(t[3:0]));
  // Gamma stream holds len-1 zeros and len code bits
  assign nbits     = BLW'({len_final, 1'b0}) - BLW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Nibble scan
  always_ff @(posedge clk) begin
    if (load) begin
      t   <= code;
      len <= '0;
    end else if (busy && !done) begin
      t   <= t >> 4;
      len <= len + LW'(4);
    end
  end

  `SGEC_ASSERT(a_no_reload_busy, load |-> !busy, "length unit reloaded while scanning")
  `SGEC_ASSERT(a_len_nonzero, done |-> (len_final != '0), "code word of zero length")

endmodule

FILE: rtl/sgec_pack.sv
// Byte packer: barrel-shifts chunks of the gamma stream into a 7-bit accumulator.
// Depends on sgec_pkg.
`include "signed_elias_gamma_encoder_defines.svh"

module sgec_pack
  import sgec_pkg::*;
#(
  parameter int CW  = 33,
  parameter int BLW = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  pack_cmd_t      cmd,
  input  logic [CW-1:0]  code,
  input  logic [BLW-1:0] nbits,
  output pack_stat_t     stat
);

  logic [CW-1:0]  src;
  logic [BLW-1:0] bits_left;
  logic [6:0]     acc;
  logic [2:0]     cnt;

  logic [3:0]     room;
  logic [3:0]     k;
  logic [BLW-1:0] shamt;
  logic [CW-1:0]  win;
  logic [7:0]     mask;
  logic [7:0]     chunk;
  logic [7:0]     merged;
  logic [3:0]     fill;
  logic           full;
  logic [7:0]     flush_byte;

  // Chunk size: what is left of the stream, or of the byte
  always_comb begin
    room   = 4'(BYTE_BITS) - {1'b0, cnt};
    k      = (bits_left < BLW'(room)) ? bits_left[3:0] : room;
    shamt  = bits_left - BLW'(k);
    // Leading zeros of the stream sit above the code word: a shift past it gives 0
    win    = src >> shamt;
    mask   = 8'((9'd1 << k) - 9'd1);
    chunk  = win[7:0] & mask;
    merged = ({1'b0, acc} << k) | chunk;
    fill   = {1'b0, cnt} + k;
    full   = (fill == 4'(BYTE_BITS));
    flush_byte = {1'b0, acc} << (4'(BYTE_BITS) - {1'b0, cnt});
  end

  // Status
  always_comb begin
    stat.pending = (cnt != '0);
    stat.emit    = (cmd.step && full) || (cmd.flush && (cnt != '0));
    stat.last    = cmd.flush || (shamt < BLW'(BYTE_BITS));
    stat.done    = cmd.step && (shamt == '0);
    stat.data    = cmd.flush ? flush_byte : merged;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src <= code;
    end
  end

  // Accumulator and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      bits_left <= '0;
    end else begin
      if (cmd.start) begin
        bits_left <= nbits;
      end else if (cmd.step) begin
        bits_left <= shamt;
      end
      if (cmd.flush || (cmd.step && full)) begin
        acc <= '0;
        cnt <= '0;
      end else if (cmd.step) begin
        acc <= merged[6:0];
        cnt <= fill[2:0];
      end
    end
  end

  `SGEC_ASSERT(a_step_has_bits, cmd.step |-> (bits_left != '0), "packer stepped on empty stream")
  `SGEC_ASSERT(a_flush_clears, cmd.flush |=> (cnt == '0), "flush left bits pending")

endmodule

FILE: rtl/signed_elias_gamma_encoder.sv
// Signed Elias gamma encoder top level: sequencer, sign mapping, result register.
// Depends on sgec_pkg, sgec_len and sgec_pack.
//
//  channel | signals                    | moves
//  --------+----------------------------+------------------------------------
//  req     | req_valid, req_stall, req  | one encode or flush request
//  res     | res_valid, res_stall, res  | one packed byte with its last flag
//
// An encode of a code word of L bits is accepted, scanned in the nibble-wide length
// finder, and packed chunk by chunk, ceil((2L-1)/8) chunks or one more, depending
// on the bits already pending; the barrel shifter moves at most one byte per cycle
// while the result is free.
// A flush pads and releases any pending bits. Only one item is in the block at a time.
// Reset clears the sequencer, the pending bits and the result valid flag.
// A stalled result holds the packer until it is taken.
`include "signed_elias_gamma_encoder_defines.svh"

module signed_elias_gamma_encoder
  import sgec_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  localparam int CW  = VALUE_BITS + 1;
  localparam int BLW = $clog2(2 * CW);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_PACK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic                  accept;
  logic                  out_free;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] neg_raw;
  logic [CW-1:0]         code;
  logic                  len_done;
  logic [BLW-1:0]        nbits;
  pack_cmd_t             cmd;
  pack_stat_t            stat;

  // Value width adaptation
  generate
    if (VALUE_BITS <= IN_VALUE_WIDTH) begin : g_trunc
      assign raw = req.value[VALUE_BITS-1:0];
    end else begin : g_sext
      assign raw = {{(VALUE_BITS - IN_VALUE_WIDTH){req.value[IN_VALUE_WIDTH-1]}}, req.value};
    end
  endgenerate

  // Sign mapping: negative to -2v, non-negative to 2v+1
  assign neg_raw = ~raw + VALUE_BITS'(1);
  assign code    = raw[VALUE_BITS-1] ? {neg_raw, 1'b0} : {raw, 1'b1};

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Sequencer
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_FLUSH) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (len_done) begin
          cmd.start  = 1'b1;
          state_next = ST_PACK;
        end
      end
      ST_PACK: begin
        if (out_free) begin
          cmd.step = 1'b1;
          if (stat.done) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pending) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stat.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      res.byte_out <= stat.data;
      res.last     <= stat.last;
    end
  end

  sgec_len #(
    .CW  (CW),
    .BLW (BLW)
  ) u_len (
    .clk   (clk),
    .rst   (rst),
    .load  (cmd.load),
    .code  (code),
    .done  (len_done),
    .nbits (nbits)
  );

  sgec_pack #(
    .CW  (CW),
    .BLW (BLW)
  ) u_pack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .code  (code),
    .nbits (nbits),
    .stat  (stat)
  );

  `SGEC_ASSERT(a_encode_scans, (accept && (req.req_type == REQ_ENCODE)) |=> (state == ST_SCAN), "encode did not start scan")
  `SGEC_ASSERT(a_emit_has_room, stat.emit |-> out_free, "byte produced over an untaken result")
  `SGEC_ASSERT_ALWAYS(a_len_in_scan, len_done |-> (state == ST_SCAN), "length found outside scan")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for signed_elias_gamma_encoder: an internal bit packer predicts every
// output byte, which is compared against the block's result channel under random back-pressure.
// Depends on sgec_pkg and the encoder RTL.
module tb;
  import sgec_pkg::*;

  localparam int VB         = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 60;
  localparam int N_RANDOM   = 370;

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  // Stimulus backlog and predicted output bytes
  req_item_t req_backlog[$];
  res_item_t coded_bytes[$];

  // Predictor copy of the packing state
  logic [6:0] acc_bits  = '0;
  logic [2:0] acc_count = '0;

  int n_total    = 0;
  int n_issued   = 0;
  int n_accepted = 0;
  int err_count  = 0;
  int idle_cycles = 0;
  int req_gap    = 0;
  int req_quiet  = 0;
  int res_left   = 0;
  int res_quiet  = 0;

  signed_elias_gamma_encoder #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Gap length: mostly short, a few long, with occasional quiet stretches
  task automatic pick_gap(inout int quiet, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else begin
      if (r < 3) quiet = $urandom_range(10, 40);
      if (r < 60)      gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 40);
    end
  endtask

  // Shift one code bit into the pending byte; emit it once complete
  task automatic shift_bit(input logic b);
    res_item_t r;
    logic [7:0] full;
    full = {acc_bits, b};
    if (acc_count == 3'd7) begin
      r.byte_out = full;
      r.last     = 1'b0;
      coded_bytes = {coded_bytes, r};
      acc_bits  = '0;
      acc_count = '0;
    end else begin
      acc_bits  = full[6:0];
      acc_count = acc_count + 3'd1;
    end
  endtask

  // Map, gamma-code and pack one item, queueing the bytes it completes
  task automatic gamma_pack(input req_item_t it);
    logic [VB-1:0] raw;
    logic [VB-1:0] mag;
    logic [VB:0]   code;
    logic [7:0]    padded;
    res_item_t     r;
    int            len;
    int            n_prior;
    n_prior = coded_bytes.size();
    if (it.req_type == REQ_FLUSH) begin
      if (acc_count != 3'd0) begin
        padded     = {1'b0, acc_bits};
        padded     = padded << (8 - int'(acc_count));
        r.byte_out = padded;
        r.last     = 1'b1;
        coded_bytes = {coded_bytes, r};
        acc_bits  = '0;
        acc_count = '0;
      end
    end else begin
      raw = it.value[VB-1:0];
      if (raw[VB-1]) begin
        mag  = ~raw + 1'b1;
        code = {mag, 1'b0};
      end else begin
        code = {raw, 1'b1};
      end
      len = 0;
      for (int i = 0; i <= VB; i++)
        if (code[i]) len = i + 1;
      for (int i = 1; i < len; i++)
        shift_bit(1'b0);
      for (int i = len - 1; i >= 0; i--)
        shift_bit(code[i]);
      // Mark the closing byte of this item
      if (coded_bytes.size() > n_prior) begin
        coded_bytes[coded_bytes.size() - 1].last = 1'b1;
      end
    end
  endtask

  task automatic add_item(input logic kind, input logic [31:0] v);
    req_item_t it;
    it.req_type = kind;
    it.value    = v;
    req_backlog = {req_backlog, it};
  endtask

  // Request driver
  always @(negedge clk) begin : drive_req
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && n_accepted != n_issued) begin
      // stalled: hold the item
    end else if (req_gap > 0) begin
      req_valid <= 1'b0;
      req_gap--;
    end else if (req_backlog.size() != 0) begin
      req       <= req_backlog.pop_front();
      req_valid <= 1'b1;
      n_issued++;
      pick_gap(req_quiet, req_gap);
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Result back-pressure
  always @(negedge clk) begin : drive_stall
    int g;
    if (rst) begin
      res_stall <= 1'b0;
    end else if (res_left > 0) begin
      res_stall <= 1'b1;
      res_left--;
    end else begin
      pick_gap(res_quiet, g);
      res_stall <= (g > 0);
      res_left = (g > 0) ? g - 1 : 0;
    end
  end

  // Monitor: check results first, then predict from the accepted item
  always @(posedge clk) begin : monitor
    res_item_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (coded_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h last %b", $time, res.byte_out, res.last);
          err_count++;
        end else begin
          want = coded_bytes.pop_front();
          if (res.byte_out !== want.byte_out) begin
            $display("%0t: byte_out mismatch exp %h got %h", $time, want.byte_out,
                     res.byte_out);
            err_count++;
          end
          if (res.last !== want.last) begin
            $display("%0t: last mismatch exp %b got %b", $time, want.last, res.last);
            err_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        gamma_pack(req);
        n_accepted++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [31:0] v;
    logic [31:0] mask;
    int r;
    int k;
    // Directed: flush with nothing pending, short code with no byte, extremes
    add_item(REQ_FLUSH,  32'h0000_0000);
    add_item(REQ_ENCODE, 32'h0000_0000);
    add_item(REQ_FLUSH,  32'hffff_ffff);
    add_item(REQ_FLUSH,  32'h0000_0000);
    add_item(REQ_ENCODE, 32'h0000_0001);
    add_item(REQ_ENCODE, 32'hffff_ffff);
    add_item(REQ_ENCODE, 32'h0000_0002);
    add_item(REQ_ENCODE, 32'hffff_fffe);
    add_item(REQ_ENCODE, 32'h0000_0003);
    add_item(REQ_ENCODE, 32'h0000_0007);
    add_item(REQ_ENCODE, 32'hffff_fff8);
    add_item(REQ_ENCODE, 32'h0000_007f);
    add_item(REQ_ENCODE, 32'hffff_ff80);
    add_item(REQ_ENCODE, 32'h7fff_ffff);
    add_item(REQ_ENCODE, 32'h8000_0000);
    add_item(REQ_FLUSH,  32'h0000_0000);
    add_item(REQ_ENCODE, 32'h8000_0001);
    add_item(REQ_ENCODE, 32'h4000_0000);
    add_item(REQ_ENCODE, 32'hc000_0000);
    add_item(REQ_ENCODE, 32'h5555_5555);
    add_item(REQ_ENCODE, 32'haaaa_aaaa);
    add_item(REQ_FLUSH,  32'h0000_0000);
    add_item(REQ_ENCODE, 32'h8000_0000);
    add_item(REQ_FLUSH,  32'h0000_0000);

    // Random: mostly small magnitudes, some full-width and extreme values, some flushes
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_item(REQ_FLUSH, $urandom);
      end else if (r < 14) begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
        add_item(REQ_ENCODE, v);
      end else if (r < 40) begin
        add_item(REQ_ENCODE, $urandom);
      end else begin
        k    = $urandom_range(0, 31);
        mask = (32'h1 << k) - 32'h1;
        v    = $urandom & mask;
        if ($urandom_range(0, 1) == 1) v = -v;
        add_item(REQ_ENCODE, v);
      end
    end
    n_total = req_backlog.size();

    while (n_accepted != n_total) @(negedge clk);
    while (coded_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
